/* design/ncct_pkg.sv */
// ----------------------------------------------------------------------------
// ncct_pkg
// Shared types and constants for the nearest center cluster tracker.
// ----------------------------------------------------------------------------
package ncct_pkg;

  localparam int unsigned TableDepthDef = 16;

  localparam logic [11:0] RADIUS_RESET = 12'd240;
  localparam logic [17:0] SPEED_LIMIT  = 18'h3FFFF;
  localparam logic [19:0] DIST_SCALE   = 20'd1000000;

  localparam int unsigned RootW = 22;
  localparam int unsigned RadW  = 44;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [47:0] t;
  } ncct_item_t;

  typedef struct packed {
    logic [15:0] id;
    logic        is_new;
    logic [17:0] speed;
    logic        sat;
    logic        evicted;
  } ncct_result_t;

endpackage

/* design/ncct_queue.sv */
// ----------------------------------------------------------------------------
// ncct_queue
// Two-entry item queue between the input port and the tracking engine.
// ----------------------------------------------------------------------------
module ncct_queue
  import ncct_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  ncct_item_t item_i,
  output logic       full_o,
  output logic       valid_o,
  output ncct_item_t item_o,
  input  logic       pop_i
);

  ncct_item_t buf_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;

  logic do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign item_o  = buf_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = do_push ? ~wr_q : wr_q;
    rd_d  = do_pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      buf_q[wr_q] <= item_i;
    end
  end

endmodule

/* design/ncct_sqrt.sv */
// ----------------------------------------------------------------------------
// ncct_sqrt
// Iterative integer square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module ncct_sqrt
  import ncct_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [RadW-1:0]  rad_i,
  output logic             done_o,
  output logic [RootW-1:0] root_o
);

  localparam int unsigned CntW = $clog2(RootW + 1);

  logic [RadW-1:0]  rad_q, rad_d;
  logic [RootW+1:0] rem_q, rem_d;
  logic [RootW-1:0] root_q, root_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;

  logic [RootW+1:0] rem_sh, trial;

  assign done_o = done_q;
  assign root_o = root_q;

  always_comb begin
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    rem_sh = {rem_q[RootW-1:0], rad_q[RadW-1 -: 2]};
    trial  = {root_q, 2'b01};
    if (start_i) begin
      rad_d  = rad_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = CntW'(RootW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rad_d = {rad_q[RadW-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_d  = rem_sh - trial;
        root_d = {root_q[RootW-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        root_d = {root_q[RootW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

endmodule

/* design/ncct_div.sv */
// ----------------------------------------------------------------------------
// ncct_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ncct_div
  import ncct_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [RootW-1:0] num_i,
  input  logic [47:0]      den_i,
  output logic             done_o,
  output logic [RootW-1:0] quo_o
);

  localparam int unsigned CntW = $clog2(RootW + 1);

  logic [RootW-1:0] num_q, num_d;
  logic [47:0]      den_q, den_d;
  logic [48:0]      rem_q, rem_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;

  logic [48:0] rem_sh;

  assign done_o = done_q;
  assign quo_o  = num_q;

  always_comb begin
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    rem_sh = {rem_q[47:0], num_q[RootW-1]};
    if (start_i) begin
      num_d  = num_i;
      den_d  = den_i;
      rem_d  = '0;
      cnt_d  = CntW'(RootW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, den_q}) begin
        rem_d = rem_sh - {1'b0, den_q};
        num_d = {num_q[RootW-2:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        num_d = {num_q[RootW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

endmodule

/* design/ncct_engine.sv */
// ----------------------------------------------------------------------------
// ncct_engine
// Back end: table scan, match decision, speed, table update, result register.
// ----------------------------------------------------------------------------
module ncct_engine
  import ncct_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TableDepthDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         item_valid_i,
  input  ncct_item_t   item_i,
  output logic         item_pop_o,
  input  logic [23:0]  rad_sq_i,
  output logic         res_valid_o,
  output ncct_result_t res_o,
  input  logic         res_stall_i
);

  localparam int unsigned IdxW = $clog2(TABLE_DEPTH);
  localparam logic [IdxW:0] DepthC = (IdxW+1)'(TABLE_DEPTH);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_RDBEST = 3'd3;
  localparam logic [2:0] S_SQRT   = 3'd4;
  localparam logic [2:0] S_DIV    = 3'd5;
  localparam logic [2:0] S_WRITE  = 3'd6;
  localparam logic [2:0] S_OUT    = 3'd7;

  logic [2:0] state_q, state_d;

  // entry storage
  logic [15:0] id_mem [TABLE_DEPTH];
  logic [15:0] x_mem  [TABLE_DEPTH];
  logic [15:0] y_mem  [TABLE_DEPTH];
  logic [47:0] t_mem  [TABLE_DEPTH];
  logic [15:0] id_rd_q, x_rd_q, y_rd_q;
  logic [47:0] t_rd_q;
  logic [IdxW-1:0] rd_addr;
  logic            wr_en;
  logic [IdxW-1:0] wr_addr;

  logic [TABLE_DEPTH-1:0] vld_q, vld_d;
  logic [IdxW-1:0]        rec_q [TABLE_DEPTH];
  logic [IdxW-1:0]        rec_d [TABLE_DEPTH];

  logic [15:0] ctr_q, ctr_d;
  logic        first_q, first_d;

  ncct_item_t cur_q;

  // scan pipeline
  logic [IdxW:0]   ptr_q;
  logic            s1_act_q, s1_vld_q;
  logic [IdxW-1:0] s1_idx_q, s1_rec_q;
  logic            s2_act_q, s2_vld_q;
  logic [IdxW-1:0] s2_idx_q, s2_rec_q;
  logic [31:0]     dx2_q, dy2_q;
  logic [15:0]     dx, dy;
  logic [32:0]     d2;

  logic            found_q, free_f_q;
  logic [IdxW:0]   count_q;
  logic [IdxW-1:0] best_q, best_rec_q, free_q, lru_q;
  logic [32:0]     best_d2_q;

  logic            match_q;
  logic [RadW-1:0] prod_q;
  logic [47:0]     dt_q;

  logic             sq_start, sq_done, dv_start, dv_done;
  logic [RootW-1:0] root, quo;

  logic [17:0]  speed_q;
  logic         sat_q;
  ncct_result_t res_q;
  logic         res_valid_q;

  logic            scan_done, out_free, full;
  logic [IdxW-1:0] slot;
  logic [15:0]     new_id;

  assign scan_done  = (ptr_q == DepthC) && !s1_act_q && !s2_act_q;
  assign out_free   = !res_valid_q || !res_stall_i;
  assign full       = (count_q == DepthC);
  assign slot       = full ? lru_q : free_q;
  assign new_id     = first_q ? ctr_q + 16'd1 : ctr_q;
  assign item_pop_o = (state_q == S_IDLE) && item_valid_i;
  assign sq_start   = (state_q == S_RDBEST);
  assign dv_start   = (state_q == S_SQRT) && sq_done && (dt_q != '0);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  assign dx = (cur_q.x >= x_rd_q) ? cur_q.x - x_rd_q : x_rd_q - cur_q.x;
  assign dy = (cur_q.y >= y_rd_q) ? cur_q.y - y_rd_q : y_rd_q - cur_q.y;
  assign d2 = {1'b0, dx2_q} + {1'b0, dy2_q};

  always_comb begin
    rd_addr = ptr_q[IdxW-1:0];
    if (state_q != S_SCAN) begin
      rd_addr = best_q;
    end
    wr_en   = (state_q == S_WRITE);
    wr_addr = match_q ? best_q : slot;
  end

  ncct_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .rad_i   (prod_q),
    .done_o  (sq_done),
    .root_o  (root)
  );

  ncct_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (dv_start),
    .num_i   (root),
    .den_i   (dt_q),
    .done_o  (dv_done),
    .quo_o   (quo)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (item_valid_i) state_d = S_SCAN;
      S_SCAN:   if (scan_done) state_d = S_DECIDE;
      S_DECIDE: state_d = (found_q && best_d2_q <= {9'd0, rad_sq_i}) ? S_RDBEST : S_WRITE;
      S_RDBEST: state_d = S_SQRT;
      S_SQRT:   if (sq_done) state_d = (dt_q == '0) ? S_WRITE : S_DIV;
      S_DIV:    if (dv_done) state_d = S_WRITE;
      S_WRITE:  state_d = S_OUT;
      S_OUT:    if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    vld_d   = vld_q;
    rec_d   = rec_q;
    ctr_d   = ctr_q;
    first_d = first_q;
    if (state_q == S_WRITE) begin
      if (match_q) begin
        for (int j = 0; j < TABLE_DEPTH; j++) begin
          if (vld_q[j] && rec_q[j] > best_rec_q) begin
            rec_d[j] = rec_q[j] - 1'b1;
          end
        end
        rec_d[best_q] = IdxW'(count_q - 1'b1);
      end else begin
        ctr_d   = new_id;
        first_d = 1'b1;
        vld_d[slot] = 1'b1;
        if (full) begin
          for (int j = 0; j < TABLE_DEPTH; j++) begin
            if (rec_q[j] != '0) begin
              rec_d[j] = rec_q[j] - 1'b1;
            end
          end
          rec_d[slot] = IdxW'(TABLE_DEPTH - 1);
        end else begin
          rec_d[slot] = count_q[IdxW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      vld_q       <= '0;
      ctr_q       <= '0;
      first_q     <= 1'b0;
      s1_act_q    <= 1'b0;
      s2_act_q    <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      vld_q    <= vld_d;
      ctr_q    <= ctr_d;
      first_q  <= first_d;
      s1_act_q <= (state_q == S_SCAN) && (ptr_q != DepthC);
      s2_act_q <= s1_act_q;
      if (state_q == S_OUT && out_free) begin
        res_valid_q <= 1'b1;
      end else if (!res_stall_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
    id_rd_q <= id_mem[rd_addr];
    x_rd_q  <= x_mem[rd_addr];
    y_rd_q  <= y_mem[rd_addr];
    t_rd_q  <= t_mem[rd_addr];
    if (wr_en) begin
      id_mem[wr_addr] <= match_q ? id_rd_q : new_id;
      x_mem[wr_addr]  <= cur_q.x;
      y_mem[wr_addr]  <= cur_q.y;
      t_mem[wr_addr]  <= cur_q.t;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_idx_q <= ptr_q[IdxW-1:0];
    s1_vld_q <= vld_q[ptr_q[IdxW-1:0]];
    s1_rec_q <= rec_q[ptr_q[IdxW-1:0]];
    s2_idx_q <= s1_idx_q;
    s2_vld_q <= s1_vld_q;
    s2_rec_q <= s1_rec_q;
    dx2_q    <= dx * dx;
    dy2_q    <= dy * dy;
    unique case (state_q)
      S_IDLE: begin
        cur_q    <= item_i;
        ptr_q    <= '0;
        found_q  <= 1'b0;
        free_f_q <= 1'b0;
        count_q  <= '0;
        free_q   <= '0;
        lru_q    <= '0;
      end
      S_SCAN: begin
        if (ptr_q != DepthC) begin
          ptr_q <= ptr_q + 1'b1;
        end
        if (s2_act_q) begin
          if (s2_vld_q) begin
            count_q <= count_q + 1'b1;
            if (s2_rec_q == '0) begin
              lru_q <= s2_idx_q;
            end
            if (!found_q || d2 < best_d2_q ||
                (d2 == best_d2_q && s2_rec_q < best_rec_q)) begin
              found_q    <= 1'b1;
              best_q     <= s2_idx_q;
              best_d2_q  <= d2;
              best_rec_q <= s2_rec_q;
            end
          end else if (!free_f_q) begin
            free_f_q <= 1'b1;
            free_q   <= s2_idx_q;
          end
        end
      end
      S_DECIDE: begin
        match_q <= found_q && best_d2_q <= {9'd0, rad_sq_i};
        prod_q  <= best_d2_q[23:0] * DIST_SCALE;
        speed_q <= '0;
        sat_q   <= 1'b0;
      end
      S_RDBEST: begin
        dt_q <= (cur_q.t >= t_rd_q) ? cur_q.t - t_rd_q : '0;
      end
      S_SQRT: begin
        if (sq_done && dt_q == '0) begin
          speed_q <= SPEED_LIMIT;
          sat_q   <= 1'b1;
        end
      end
      S_DIV: begin
        if (dv_done) begin
          if (quo > RootW'(SPEED_LIMIT)) begin
            speed_q <= SPEED_LIMIT;
            sat_q   <= 1'b1;
          end else begin
            speed_q <= quo[17:0];
            sat_q   <= 1'b0;
          end
        end
      end
      S_WRITE: ;
      S_OUT: begin
        // counter already holds the new ID here
        if (out_free) begin
          res_q.id      <= match_q ? id_rd_q : ctr_q;
          res_q.is_new  <= !match_q;
          res_q.speed   <= speed_q;
          res_q.sat     <= sat_q;
          res_q.evicted <= !match_q && full;
        end
      end
      default: ;
    endcase
  end

endmodule

/* design/nearest_center_cluster_tracker.sv */
// ----------------------------------------------------------------------------
// nearest_center_cluster_tracker
// Assigns track IDs to cluster centers by nearest stored center.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o) takes one cluster center with its
// timestamp per item; a two-item queue sits in front of the engine.
// Output channel (out_valid_o / out_stall_i) gives one result per item:
// ID, new flag, speed with saturation flag and eviction flag.
// Config channel (cfg_valid_i / cfg_ready_o) writes match_radius; always ready.
// Each matched item takes a pipelined scan over the entry table, then a
// square root and a divider; zero dt skips the divider, and new clusters
// skip both. Items are processed one at a time: the engine takes no new item
// until it has placed the last item's result in the output register.
// Reset empties the table, clears the ID counter and sets radius to 240.
// A stalled result holds in the output register; the engine waits behind it
// while the queue keeps taking up to two items.
// ----------------------------------------------------------------------------
module nearest_center_cluster_tracker
  import ncct_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TableDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] center_x_i,
  input  logic [15:0] center_y_i,
  input  logic [47:0] arrival_time_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] cluster_id_o,
  output logic        is_new_o,
  output logic [17:0] speed_o,
  output logic        speed_saturated_o,
  output logic        evicted_entry_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [11:0] cfg_data_i
);

  logic [23:0]  rad_sq_q;
  ncct_item_t   in_item, q_item;
  logic         q_valid, q_pop;
  ncct_result_t res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rad_sq_q <= 24'(RADIUS_RESET) * 24'(RADIUS_RESET);
    end else if (cfg_valid_i && cfg_ready_o) begin
      rad_sq_q <= 24'(cfg_data_i) * 24'(cfg_data_i);
    end
  end

  assign in_item.x = center_x_i;
  assign in_item.y = center_y_i;
  assign in_item.t = arrival_time_i;

  ncct_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_valid_i),
    .item_i  (in_item),
    .full_o  (in_stall_o),
    .valid_o (q_valid),
    .item_o  (q_item),
    .pop_i   (q_pop)
  );

  ncct_engine #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (q_valid),
    .item_i       (q_item),
    .item_pop_o   (q_pop),
    .rad_sq_i     (rad_sq_q),
    .res_valid_o  (out_valid_o),
    .res_o        (res),
    .res_stall_i  (out_stall_i)
  );

  assign cluster_id_o      = res.id;
  assign is_new_o          = res.is_new;
  assign speed_o           = res.speed;
  assign speed_saturated_o = res.sat;
  assign evicted_entry_o   = res.evicted;

endmodule
